FILE: rtl/core/psc_pkg.sv
`default_nettype none
package psc_pkg;

    // Field widths
    localparam int unsigned FIX_W   = 32;
    localparam int unsigned EN_W    = 16;
    localparam int unsigned COLOR_W = 32;
    localparam int unsigned CH_W    = 8;
    localparam int unsigned NUM_CH  = COLOR_W / CH_W;

    // Fade division: |n - e| * |s - t| fits in 24 bits, 4 quotient bits per stage
    localparam int unsigned PROD_W     = 24;
    localparam int unsigned DIV_STEP_N = 4;
    localparam int unsigned DIV_STAGES = PROD_W / DIV_STEP_N;

    // Stream and register port widths
    localparam int unsigned S_DATA_W = 6 * FIX_W + 2 * EN_W + COLOR_W;
    localparam int unsigned M_DATA_W = 4 * FIX_W + EN_W + COLOR_W;
    localparam int unsigned ADDR_W   = 3;
    localparam int unsigned APB_W    = 32;
    localparam logic [COLOR_W-1:0] COLOR_RESET = 32'hFFFF_FFFF;

    // Register index, taken from paddr[2]
    typedef enum logic {
        REG_START_COLOR = 1'b0,
        REG_END_COLOR   = 1'b1
    } psc_reg_t;

    // Kinematic and bookkeeping payload carried down the pipeline
    typedef struct packed {
        logic [FIX_W-1:0]   pos_x;
        logic [FIX_W-1:0]   pos_y;
        logic [FIX_W-1:0]   vel_x;
        logic [FIX_W-1:0]   vel_y;
        logic [EN_W-1:0]    new_energy;
        logic               dead;
        logic               fade;
        logic [COLOR_W-1:0] cur_color;
    } psc_kin_t;

    // Per-channel restoring division state
    typedef struct packed {
        logic [EN_W-1:0]   rem;
        logic [PROD_W-1:0] dq;
        logic              neg;
        logic [CH_W-1:0]   s;
    } psc_div_t;

    typedef psc_div_t [NUM_CH-1:0] psc_div_vec_t;

endpackage
`default_nettype wire

FILE: rtl/core/psc_front.sv
`default_nettype none
module psc_front (
    input  wire logic                        aclk,
    input  wire logic                        ld1,
    input  wire logic                        ld2,
    input  wire logic [psc_pkg::S_DATA_W-1:0] in_data,
    input  wire logic [psc_pkg::COLOR_W-1:0]  start_color,
    input  wire logic [psc_pkg::COLOR_W-1:0]  end_color,
    output psc_pkg::psc_kin_t                 kin_out,
    output psc_pkg::psc_div_vec_t             div_out,
    output logic [psc_pkg::EN_W-1:0]          divisor_out
);
    import psc_pkg::*;

    logic [FIX_W-1:0]   in_pos_x, in_pos_y, in_vel_x, in_vel_y, in_acc_x, in_acc_y;
    logic [EN_W-1:0]    in_energy, in_init;
    logic [COLOR_W-1:0] in_color;
    logic [EN_W-1:0]    ne;
    logic               dead;
    logic [EN_W:0]      num_e;

    psc_kin_t           kin1_reg, kin1_next, kin2_reg, kin2_next;
    logic [EN_W-1:0]    mag1_reg, mag1_next;
    logic               neg1_reg, neg1_next;
    logic [EN_W-1:0]    n1_reg, n2_reg;
    psc_div_vec_t       div2_reg, div2_next;

    // Unpack the input transaction
    assign in_pos_x  = in_data[0*FIX_W +: FIX_W];
    assign in_pos_y  = in_data[1*FIX_W +: FIX_W];
    assign in_vel_x  = in_data[2*FIX_W +: FIX_W];
    assign in_vel_y  = in_data[3*FIX_W +: FIX_W];
    assign in_acc_x  = in_data[4*FIX_W +: FIX_W];
    assign in_acc_y  = in_data[5*FIX_W +: FIX_W];
    assign in_energy = in_data[6*FIX_W +: EN_W];
    assign in_init   = in_data[6*FIX_W+EN_W +: EN_W];
    assign in_color  = in_data[6*FIX_W+2*EN_W +: COLOR_W];

    // Stage 1: velocity update, energy decrement, fade numerator
    always_comb begin
        ne    = (in_energy == '0) ? '0 : in_energy - EN_W'(1);
        dead  = (ne == '0);
        num_e = {1'b0, in_init} - {1'b0, ne};
        kin1_next.pos_x      = in_pos_x;
        kin1_next.pos_y      = in_pos_y;
        kin1_next.vel_x      = in_vel_x + in_acc_x;
        kin1_next.vel_y      = in_vel_y + in_acc_y;
        kin1_next.new_energy = ne;
        kin1_next.dead       = dead;
        kin1_next.fade       = !dead && (in_init != '0) && (start_color != end_color);
        kin1_next.cur_color  = in_color;
        neg1_next = num_e[EN_W];
        mag1_next = num_e[EN_W] ? EN_W'(-num_e) : num_e[EN_W-1:0];
    end

    // Stage 2: position update, per-channel product and sign
    always_comb begin
        logic [CH_W:0]   diff;
        logic [CH_W-1:0] dmag;
        kin2_next       = kin1_reg;
        kin2_next.pos_x = kin1_reg.pos_x + kin1_reg.vel_x;
        kin2_next.pos_y = kin1_reg.pos_y + kin1_reg.vel_y;
        for (int c = 0; c < NUM_CH; c++) begin
            diff = {1'b0, start_color[c*CH_W +: CH_W]} - {1'b0, end_color[c*CH_W +: CH_W]};
            dmag = diff[CH_W] ? CH_W'(-diff) : diff[CH_W-1:0];
            div2_next[c].rem = '0;
            div2_next[c].dq  = PROD_W'(mag1_reg * dmag);
            div2_next[c].neg = neg1_reg ^ diff[CH_W];
            div2_next[c].s   = start_color[c*CH_W +: CH_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (ld1) begin
            kin1_reg <= kin1_next;
            mag1_reg <= mag1_next;
            neg1_reg <= neg1_next;
            n1_reg   <= in_init;
        end
        if (ld2) begin
            kin2_reg <= kin2_next;
            div2_reg <= div2_next;
            n2_reg   <= n1_reg;
        end
    end

    assign kin_out     = kin2_reg;
    assign div_out     = div2_reg;
    assign divisor_out = n2_reg;

endmodule
`default_nettype wire

FILE: rtl/core/psc_div_stage.sv
`default_nettype none
module psc_div_stage (
    input  wire logic                    aclk,
    input  wire logic                    ld,
    input  wire psc_pkg::psc_kin_t       kin_in,
    input  wire psc_pkg::psc_div_vec_t   div_in,
    input  wire logic [psc_pkg::EN_W-1:0] divisor_in,
    output psc_pkg::psc_kin_t            kin_out,
    output psc_pkg::psc_div_vec_t        div_out,
    output logic [psc_pkg::EN_W-1:0]     divisor_out
);
    import psc_pkg::*;

    psc_kin_t        kin_reg;
    psc_div_vec_t    div_reg, div_next;
    logic [EN_W-1:0] divisor_reg;

    // Retire DIV_STEP_N quotient bits per channel, restoring division
    always_comb begin
        logic [EN_W:0] r;
        div_next = div_in;
        for (int c = 0; c < NUM_CH; c++) begin
            for (int k = 0; k < DIV_STEP_N; k++) begin
                r = {div_next[c].rem, div_next[c].dq[PROD_W-1]};
                if (r >= {1'b0, divisor_in}) begin
                    div_next[c].rem = EN_W'(r - {1'b0, divisor_in});
                    div_next[c].dq  = {div_next[c].dq[PROD_W-2:0], 1'b1};
                end else begin
                    div_next[c].rem = r[EN_W-1:0];
                    div_next[c].dq  = {div_next[c].dq[PROD_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld) begin
            kin_reg     <= kin_in;
            div_reg     <= div_next;
            divisor_reg <= divisor_in;
        end
    end

    assign kin_out     = kin_reg;
    assign div_out     = div_reg;
    assign divisor_out = divisor_reg;

endmodule
`default_nettype wire

FILE: rtl/core/psc_back.sv
`default_nettype none
module psc_back (
    input  wire logic                         aclk,
    input  wire logic                         ld,
    input  wire psc_pkg::psc_kin_t            kin_in,
    input  wire psc_pkg::psc_div_vec_t        div_in,
    output logic [psc_pkg::M_DATA_W-1:0]      out_data,
    output logic                              out_dead
);
    import psc_pkg::*;

    logic [COLOR_W-1:0]  color;
    logic [M_DATA_W-1:0] data_reg, data_next;
    logic                dead_reg;

    // Apply the signed quotient to the start channel and clamp to 0..255
    always_comb begin
        logic [PROD_W:0] sum;
        for (int c = 0; c < NUM_CH; c++) begin
            sum = {1'b0, div_in[c].dq} + (PROD_W+1)'(div_in[c].s);
            if (div_in[c].neg) begin
                color[c*CH_W +: CH_W] = (sum > (PROD_W+1)'(255)) ? 8'hFF : sum[CH_W-1:0];
            end else if (div_in[c].dq > PROD_W'(div_in[c].s)) begin
                color[c*CH_W +: CH_W] = '0;
            end else begin
                color[c*CH_W +: CH_W] = div_in[c].s - div_in[c].dq[CH_W-1:0];
            end
        end
    end

    // Pack the result transaction
    always_comb begin
        data_next = {kin_in.fade ? color : kin_in.cur_color,
                     kin_in.new_energy,
                     kin_in.vel_y, kin_in.vel_x,
                     kin_in.pos_y, kin_in.pos_x};
    end

    always_ff @(posedge aclk) begin
        if (ld) begin
            data_reg <= data_next;
            dead_reg <= kin_in.dead;
        end
    end

    assign out_data = data_reg;
    assign out_dead = dead_reg;

endmodule
`default_nettype wire

FILE: rtl/core/particle_step_color_fade.sv
// Particle step with color fade.
// Input stream (s_*): one particle record per transaction; the result stream (m_*)
// returns one updated record per input, in order. Velocity gains acceleration and
// position gains the new velocity (Q16.16, wrapping); energy drops by one,
// saturating at zero; m_tuser flags a dead particle. Live particles get each RGBA
// channel faded from start_color toward end_color by remaining energy.
// Colors are written over the APB port (start_color at 0x0, end_color at 0x4)
// while the stream is idle.
// Two front stages, six divider stages that each retire four quotient bits of the
// fade division, and one output stage; the divider is fully pipelined.
// Throughput is one transaction per cycle while the output is not stalled.
// Each stage holds its contents only while the stage after it is full and
// stalled, so bubbles close up and input is still taken while a result waits
// on m_tready. s_tready drops only when all nine stages hold data.
// Reset clears all stage valid bits and sets both colors to 0xFFFFFFFF.
`default_nettype none
module particle_step_color_fade (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // pos_x, pos_y, vel_x, vel_y, acc_x, acc_y, energy, init_energy, cur_color
    input  wire logic [psc_pkg::S_DATA_W-1:0]  s_tdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // new_pos_x, new_pos_y, new_vel_x, new_vel_y, new_energy, new_color
    output logic [psc_pkg::M_DATA_W-1:0]       m_tdata,
    // dead
    output logic                               m_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [psc_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [psc_pkg::APB_W-1:0]     pwdata,
    output logic [psc_pkg::APB_W-1:0]          prdata,
    output logic                               pready
);
    import psc_pkg::*;

    localparam int unsigned NSTG = DIV_STAGES + 3;

    logic [COLOR_W-1:0] start_color_reg, start_color_next;
    logic [COLOR_W-1:0] end_color_reg, end_color_next;
    logic [NSTG-1:0]    v_reg, v_next;
    logic [NSTG-1:0]    en;
    psc_reg_t           wr_sel;

    psc_kin_t           kin_pipe [DIV_STAGES+1];
    psc_div_vec_t       div_pipe [DIV_STAGES+1];
    logic [EN_W-1:0]    n_pipe   [DIV_STAGES+1];

    // Register file
    assign pready = 1'b1;
    assign wr_sel = psc_reg_t'(paddr[2]);

    always_comb begin
        start_color_next = start_color_reg;
        end_color_next   = end_color_reg;
        if (psel && penable && pwrite) begin
            case (wr_sel)
                REG_START_COLOR: start_color_next = pwdata;
                REG_END_COLOR:   end_color_next   = pwdata;
                default:         start_color_next = start_color_reg;
            endcase
        end
    end

    always_comb begin
        case (wr_sel)
            REG_START_COLOR: prdata = start_color_reg;
            REG_END_COLOR:   prdata = end_color_reg;
            default:         prdata = '0;
        endcase
    end

    // Stage enables: a stage loads when empty or when its successor moves
    always_comb begin
        en[NSTG-1] = !v_reg[NSTG-1] || m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    // Advance valid bits alongside the data
    always_comb begin
        v_next[0] = en[0] ? s_tvalid : v_reg[0];
        for (int k = 1; k < NSTG; k++) begin
            if (en[k]) begin
                v_next[k] = v_reg[k-1];
            end else begin
                v_next[k] = v_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg           <= '0;
            start_color_reg <= COLOR_RESET;
            end_color_reg   <= COLOR_RESET;
        end else begin
            v_reg           <= v_next;
            start_color_reg <= start_color_next;
            end_color_reg   <= end_color_next;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[NSTG-1];

    psc_front u_front (
        .aclk        (aclk),
        .ld1         (en[0]),
        .ld2         (en[1]),
        .in_data     (s_tdata),
        .start_color (start_color_reg),
        .end_color   (end_color_reg),
        .kin_out     (kin_pipe[0]),
        .div_out     (div_pipe[0]),
        .divisor_out (n_pipe[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        psc_div_stage u_div (
            .aclk        (aclk),
            .ld          (en[g+2]),
            .kin_in      (kin_pipe[g]),
            .div_in      (div_pipe[g]),
            .divisor_in  (n_pipe[g]),
            .kin_out     (kin_pipe[g+1]),
            .div_out     (div_pipe[g+1]),
            .divisor_out (n_pipe[g+1])
        );
    end

    psc_back u_back (
        .aclk     (aclk),
        .ld       (en[NSTG-1]),
        .kin_in   (kin_pipe[DIV_STAGES]),
        .div_in   (div_pipe[DIV_STAGES]),
        .out_data (m_tdata),
        .out_dead (m_tuser)
    );

endmodule
`default_nettype wire

FILE: rtl/core/psc_checker.sv
`default_nettype none
module psc_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_tvalid,
    input wire logic                         s_tready,
    input wire logic [psc_pkg::M_DATA_W-1:0] m_tdata,
    input wire logic                         m_tuser,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic                         pready
);
    import psc_pkg::*;

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds its value
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Dead flag agrees with the new energy
    a_dead_energy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == (m_tdata[4*FIX_W +: EN_W] == '0)))
        else $error("dead flag disagrees with new energy");

    // Input backpressure only when the output is stalled
    a_back_pressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while output can drain");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready low");

endmodule

bind particle_step_color_fade psc_checker u_psc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .pready   (pready)
);
`default_nettype wire
